### rtl/keyframe_track_sampler_core_macros.svh
// assertion macros shared by the keyframe track sampler rtl
`ifndef KEYFRAME_TRACK_SAMPLER_CORE_MACROS_SVH
`define KEYFRAME_TRACK_SAMPLER_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define KTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kts assertion failed");

// next-cycle implication, clocked on clk, off during rst
`define KTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kts assertion failed");

`endif

### rtl/kts_pkg.sv
// shared types, constants and helpers for the keyframe track sampler
package kts_pkg;

  localparam int MAX_KEYS_DEF = 256;
  localparam int CNT_W        = 9;
  localparam int DIV_NUM_W    = 48;
  localparam int DIV_DEN_W    = 32;
  localparam int ALPHA_W      = 17;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

  // one table row: key time and four packed components
  typedef struct packed {
    logic [31:0] ktime;
    logic [63:0] vlow;
    logic [63:0] vhigh;
  } key_entry_t;

  typedef enum logic [1:0] {
    REG_CLIP_DURATION = 2'd0,
    REG_LOOP_MODE     = 2'd1,
    REG_TIME_COUNT    = 2'd2,
    REG_VALUE_COUNT   = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_DIV,
    ST_SRCH_ISSUE,
    ST_SRCH_CMP,
    ST_SEG_FIX,
    ST_RD_NEXT,
    ST_CAP_NEXT,
    ST_ALPHA_DIV,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
    logic [DIV_DEN_W-1:0] rem;
  } div_rsp_t;

  // pick one signed component out of a table row
  function automatic logic signed [31:0] comp_of(key_entry_t e, logic [1:0] c);
    logic signed [31:0] v;
    unique case (c)
      2'd0: v = e.vlow[31:0];
      2'd1: v = e.vlow[63:32];
      2'd2: v = e.vhigh[31:0];
      default: v = e.vhigh[63:32];
    endcase
    return v;
  endfunction

endpackage

### rtl/keyframe_track_sampler_core.sv
// keyframe track sampler top level: sequencer, time mapping, search and blend
//
// Input channel (in_valid/in_stall): action 0 writes key_slot of the key table
// (slots at or beyond MAX_KEYS are dropped) and gives no result; action 1
// samples the track at query_time and gives one result on the output channel.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready; the
// user must write it only while the block is idle, which is not enforced.
// A key write is made as it is accepted. A sample with no key values goes
// straight to the result; otherwise a loop wrap runs through the shared
// bit-serial divider, the upper-bound search issues and compares one probe at
// a time on the single read port of the key memory (up to nine probes) and
// then finishes, two more memory reads fetch the segment ends, an alpha division
// runs through the divider when the time falls strictly inside a segment, and
// the four components go through one multiplier in turn.
// The block takes one request at a time; in_stall is high while a sample is in
// work. A finished result waits in the output register while the next request
// is taken; if out_stall holds it there, a following sample waits in its last
// step until the register frees.
// Reset clears the configuration registers and control state; the key table
// holds no defined contents until written, and needs no clearing pass.
`include "keyframe_track_sampler_core_macros.svh"

module keyframe_track_sampler_core import kts_pkg::*; #(
  parameter int MAX_KEYS = MAX_KEYS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  key_slot,
  input  logic [31:0] key_time,
  input  logic [31:0] value_x,
  input  logic [31:0] value_y,
  input  logic [31:0] value_z,
  input  logic [31:0] value_w,
  input  logic [31:0] query_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_z,
  output logic [31:0] out_w,
  output logic [7:0]  segment_index
);

  localparam int AW = $clog2(MAX_KEYS);

  state_t state, state_next;

  // configuration registers
  logic [30:0]      clip_duration;
  logic             loop_mode;
  logic [CNT_W-1:0] time_count;
  logic [CNT_W-1:0] value_count;

  // per-request working registers
  logic [CNT_W-1:0]   tc, vc;
  logic signed [31:0] tq;
  logic               qneg;
  logic [CNT_W-1:0]   first, count, seg, nxt;
  key_entry_t         ea, eb;
  logic [ALPHA_W-1:0] alpha;
  logic [1:0]         comp;
  logic signed [50:0] prod;
  logic [31:0]        res [4];

  // memory and divider hookup
  logic          wr_en;
  logic [AW-1:0] rd_addr;
  key_entry_t    wr_data, rd_data;
  div_req_t      div_req;
  div_rsp_t      div_rsp;

  // combinational helpers
  logic               accept, take_sample, out_free;
  logic [CNT_W-1:0]   tc_in, vc_in;
  logic signed [31:0] dur, q_clamp, q_abs, t_wrap, t0, t1;
  logic [CNT_W-1:0]   step, vm1, seg_c, nxt_c, seg_srch;
  logic signed [32:0] t_off, t_span;
  logic signed [32:0] diff_w;
  logic signed [17:0] alpha_s;
  logic signed [31:0] ca, cb;
  logic signed [50:0] sum_w;
  logic               key_lt;

  assign cfg_ready   = 1'b1;
  assign in_stall    = (state != ST_IDLE);
  assign accept      = in_valid && !in_stall;
  assign take_sample = accept && action;
  assign out_free    = !out_valid || !out_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_duration <= '0;
      loop_mode     <= 1'b0;
      time_count    <= '0;
      value_count   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CLIP_DURATION: clip_duration <= cfg_data[30:0];
        REG_LOOP_MODE:     loop_mode     <= cfg_data[0];
        REG_TIME_COUNT:    time_count    <= cfg_data[CNT_W-1:0];
        REG_VALUE_COUNT:   value_count   <= cfg_data[CNT_W-1:0];
      endcase
    end
  end

  // counts limited to the table depth
  assign tc_in = (32'(time_count) > MAX_KEYS) ? CNT_W'(MAX_KEYS) : time_count;
  assign vc_in = (32'(value_count) > MAX_KEYS) ? CNT_W'(MAX_KEYS) : value_count;

  // time mapping: clamp, and wrap fixup after the remainder
  assign dur     = $signed({1'b0, clip_duration});
  assign q_clamp = $signed(query_time) < 0 ? 32'sd0 :
                   ($signed(query_time) > dur ? dur : $signed(query_time));
  assign q_abs   = query_time[31] ? -$signed(query_time) : $signed(query_time);
  assign t_wrap  = (qneg && div_rsp.rem != '0) ? dur - $signed(div_rsp.rem) :
                   $signed(div_rsp.rem);

  // search probe and segment end result
  assign step     = count >> 1;
  assign key_lt   = tq < $signed(rd_data.ktime);
  assign seg_srch = (first == '0) ? '0 : ((first == tc) ? tc - 2'd2 : first - 1'b1);

  // segment limited to the values, next index limited likewise
  assign vm1   = vc - 1'b1;
  assign seg_c = (seg > vm1) ? vm1 : seg;
  assign nxt_c = ((seg_c + 1'b1) < vm1) ? seg_c + 1'b1 : vm1;

  // segment end times
  assign t0     = $signed(ea.ktime);
  assign t1     = (nxt < tc) ? $signed(rd_data.ktime) : t0;
  assign t_off  = {tq[31], tq} - {t0[31], t0};
  assign t_span = {t1[31], t1} - {t0[31], t0};

  // blend arithmetic
  assign ca      = comp_of(ea, comp);
  assign cb      = comp_of(eb, comp);
  assign diff_w  = {cb[31], cb} - {ca[31], ca};
  assign alpha_s = $signed({1'b0, alpha});
  assign sum_w   = prod + 51'sd32768;

  // memory ports
  assign wr_en         = accept && !action && (32'(key_slot) < MAX_KEYS);
  assign wr_data.ktime = key_time;
  assign wr_data.vlow  = {value_y, value_x};
  assign wr_data.vhigh = {value_w, value_z};

  always_comb begin
    unique case (state)
      ST_SRCH_ISSUE: rd_addr = AW'(first + step);
      ST_SEG_FIX:    rd_addr = AW'(seg_c);
      ST_RD_NEXT:    rd_addr = AW'(nxt);
      default:       rd_addr = '0;
    endcase
  end

  // divider requests: loop wrap on accept, alpha inside a segment
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = {16'b0, q_abs};
    div_req.den   = {1'b0, clip_duration};
    if (state == ST_IDLE) begin
      div_req.start = take_sample && vc_in > 9'd1 && tc_in != '0 && loop_mode &&
                      clip_duration != '0;
    end else if (state == ST_CAP_NEXT) begin
      div_req.num   = {t_off[31:0], 16'b0};
      div_req.den   = t_span[31:0];
      div_req.start = (t1 > t0) && (tq > t0) && (tq < t1);
    end
  end

  kts_key_mem #(.MAX_KEYS(MAX_KEYS)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(key_slot)),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  kts_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take_sample) begin
          if (vc_in == '0) begin
            state_next = ST_DONE;
          end else if (vc_in == 9'd1 || tc_in == '0) begin
            state_next = ST_SEG_FIX;
          end else if (div_req.start) begin
            state_next = ST_MAP_DIV;
          end else begin
            state_next = ST_SRCH_ISSUE;
          end
        end
      end
      ST_MAP_DIV:    if (div_rsp.done) state_next = ST_SRCH_ISSUE;
      ST_SRCH_ISSUE: state_next = (tc < 9'd2 || count == '0) ? ST_SEG_FIX : ST_SRCH_CMP;
      ST_SRCH_CMP:   state_next = ST_SRCH_ISSUE;
      ST_SEG_FIX:    state_next = ST_RD_NEXT;
      ST_RD_NEXT:    state_next = ST_CAP_NEXT;
      ST_CAP_NEXT:   state_next = div_req.start ? ST_ALPHA_DIV : ST_MUL;
      ST_ALPHA_DIV:  if (div_rsp.done) state_next = ST_MUL;
      ST_MUL:        state_next = ST_ADD;
      ST_ADD:        state_next = (comp == 2'd3) ? ST_DONE : ST_MUL;
      ST_DONE:       if (out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        tc    <= tc_in;
        vc    <= vc_in;
        qneg  <= query_time[31];
        first <= '0;
        count <= tc_in;
        seg   <= '0;
        comp  <= '0;
        tq    <= (clip_duration == '0) ? 32'sd0 : q_clamp;
        for (int i = 0; i < 4; i++) begin
          res[i] <= '0;
        end
      end
      ST_MAP_DIV: begin
        if (div_rsp.done) begin
          tq <= t_wrap;
        end
      end
      ST_SRCH_ISSUE: begin
        if (tc < 9'd2) begin
          seg <= '0;
        end else if (count == '0) begin
          seg <= seg_srch;
        end
      end
      ST_SRCH_CMP: begin
        if (!key_lt) begin
          first <= first + step + 1'b1;
          count <= count - step - 1'b1;
        end else begin
          count <= step;
        end
      end
      ST_SEG_FIX: begin
        seg <= seg_c;
        nxt <= nxt_c;
      end
      ST_RD_NEXT: begin
        ea <= rd_data;
      end
      ST_CAP_NEXT: begin
        eb <= rd_data;
        if (t1 > t0 && tq >= t1) begin
          alpha <= ALPHA_ONE;
        end else begin
          alpha <= '0;
        end
      end
      ST_ALPHA_DIV: begin
        if (div_rsp.done) begin
          alpha <= div_rsp.quot[ALPHA_W-1:0];
        end
      end
      ST_MUL: begin
        prod <= diff_w * alpha_s;
      end
      ST_ADD: begin
        res[comp] <= ca + sum_w[47:16];
        comp      <= comp + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_x         <= res[0];
      out_y         <= res[1];
      out_z         <= res[2];
      out_w         <= res[3];
      segment_index <= seg[7:0];
    end
  end

  `KTS_ASSERT_NEXT(a_done_loads_out, state == ST_DONE && !out_valid, out_valid)
  `KTS_ASSERT_NOW(a_div_done_waited, div_rsp.done,
                  state == ST_MAP_DIV || state == ST_ALPHA_DIV)
  `KTS_ASSERT_NOW(a_alpha_range, state == ST_MUL, alpha <= ALPHA_ONE)
  `KTS_ASSERT_NOW(a_search_bounds, state == ST_SRCH_ISSUE,
                  (10'(first) + 10'(count)) <= 10'(tc))

endmodule

### rtl/kts_key_mem.sv
// key table memory: one write port, one registered read port
module kts_key_mem import kts_pkg::*; #(
  parameter int MAX_KEYS = MAX_KEYS_DEF,
  localparam int AW = $clog2(MAX_KEYS)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  key_entry_t    wr_data,
  input  logic [AW-1:0] rd_addr,
  output key_entry_t    rd_data
);

  key_entry_t mem [MAX_KEYS];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/kts_divider.sv
// restoring unsigned divider, one quotient bit per cycle
module kts_divider import kts_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int SW = $clog2(DIV_NUM_W);

  logic                 busy;
  logic                 done;
  logic [SW-1:0]        cnt;
  logic [DIV_NUM_W-1:0] quot;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  // trial subtract of the shifted remainder
  assign shifted = {rem, quot[DIV_NUM_W-1]};
  assign diff    = shifted - {1'b0, den};
  assign ge      = shifted >= {1'b0, den};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= SW'(DIV_NUM_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // datapath, quotient shifts in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= req.num;
      den  <= req.den;
      rem  <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
      quot <= {quot[DIV_NUM_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule

### tb/kts_tb_pkg.sv
// request codes and expected result type shared by the sampler testbench and checker
package kts_tb_pkg;

  localparam logic ACT_KEY_WRITE = 1'b0;
  localparam logic ACT_SAMPLE    = 1'b1;

  // one expected sample result
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
    logic [7:0]  seg;
  } sample_res_t;

endpackage

### tb/keyframe_track_sampler_checker.sv
// checker for the keyframe sampler: tracks the key table, predicts samples, compares
module keyframe_track_sampler_checker import kts_pkg::*; import kts_tb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        action,
  input  logic [7:0]  key_slot,
  input  logic [31:0] key_time,
  input  logic [31:0] value_x,
  input  logic [31:0] value_y,
  input  logic [31:0] value_z,
  input  logic [31:0] value_w,
  input  logic [31:0] query_time,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_x,
  input  logic [31:0] out_y,
  input  logic [31:0] out_z,
  input  logic [31:0] out_w,
  input  logic [7:0]  segment_index,
  output int          fail_count,
  output int          pending
);

  localparam int NKEYS = 256;

  // shadow key table and configuration
  logic signed [31:0] shadow_time [NKEYS];
  logic signed [31:0] shadow_val [NKEYS][4];
  logic [30:0] dur_q;
  logic        loop_q;
  logic [8:0]  tcount_q;
  logic [8:0]  vcount_q;

  sample_res_t expected_samples[$];

  // fold query time into the clip
  function automatic longint clip_time(longint t);
    longint d;
    longint r;
    d = longint'(dur_q);
    if (d <= 0) return 0;
    if (loop_q) begin
      r = t % d;
      if (r < 0) r += d;
      return r;
    end
    if (t < 0) return 0;
    if (t > d) return d;
    return t;
  endfunction

  // upper-bound search for the segment, ends clamped
  function automatic int locate_span(int n, longint t);
    int first;
    int cnt;
    int step;
    first = 0;
    cnt = n;
    if (n < 2) return 0;
    while (cnt > 0) begin
      step = cnt / 2;
      if (!(t < longint'(shadow_time[first + step]))) begin
        first += step + 1;
        cnt -= step + 1;
      end else begin
        cnt = step;
      end
    end
    if (first == 0) return 0;
    if (first == n) return n - 2;
    return first - 1;
  endfunction

  // linear blend with round half up
  function automatic logic [31:0] lerp(longint a, longint b, longint alpha);
    longint r;
    r = a + (((b - a) * alpha + 32768) >>> 16);
    return r[31:0];
  endfunction

  function automatic sample_res_t sample_track(logic [31:0] q);
    sample_res_t r;
    int tc;
    int vc;
    int seg;
    int nxt;
    longint t;
    longint t0;
    longint t1;
    longint alpha;
    longint unsigned num;
    tc = (tcount_q > NKEYS) ? NKEYS : int'(tcount_q);
    vc = (vcount_q > NKEYS) ? NKEYS : int'(vcount_q);
    r = '0;
    if (vc == 1 || (vc > 1 && tc == 0)) begin
      r.x = shadow_val[0][0];
      r.y = shadow_val[0][1];
      r.z = shadow_val[0][2];
      r.w = shadow_val[0][3];
    end else if (vc > 1) begin
      t = clip_time(longint'($signed(q)));
      seg = locate_span(tc, t);
      if (seg > vc - 1) seg = vc - 1;
      nxt = (seg + 1 < vc - 1) ? seg + 1 : vc - 1;
      t0 = longint'(shadow_time[seg]);
      t1 = (nxt < tc) ? longint'(shadow_time[nxt]) : t0;
      alpha = 0;
      if (t1 > t0) begin
        if (t <= t0) alpha = 0;
        else if (t >= t1) alpha = 65536;
        else begin
          num = longint'(t - t0) << 16;
          alpha = longint'(num / longint'(t1 - t0));
        end
      end
      r.x = lerp(shadow_val[seg][0], shadow_val[nxt][0], alpha);
      r.y = lerp(shadow_val[seg][1], shadow_val[nxt][1], alpha);
      r.z = lerp(shadow_val[seg][2], shadow_val[nxt][2], alpha);
      r.w = lerp(shadow_val[seg][3], shadow_val[nxt][3], alpha);
      r.seg = seg[7:0];
    end
    return r;
  endfunction

  // watch all three channels
  always @(posedge clk) begin
    sample_res_t e;
    if (rst) begin
      dur_q <= '0;
      loop_q <= 1'b0;
      tcount_q <= '0;
      vcount_q <= '0;
      expected_samples.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_CLIP_DURATION: dur_q <= cfg_data[30:0];
          REG_LOOP_MODE:     loop_q <= cfg_data[0];
          REG_TIME_COUNT:    tcount_q <= cfg_data[8:0];
          REG_VALUE_COUNT:   vcount_q <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("unexpected sample result seg=%0d x=%h", segment_index, out_x);
        end else begin
          e = expected_samples.pop_front();
          if (out_x !== e.x || out_y !== e.y || out_z !== e.z || out_w !== e.w ||
              segment_index !== e.seg) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch exp %h %h %h %h seg %0d, got %h %h %h %h seg %0d",
                       e.x, e.y, e.z, e.w, e.seg,
                       out_x, out_y, out_z, out_w, segment_index);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (action == ACT_KEY_WRITE) begin
          shadow_time[key_slot] <= key_time;
          shadow_val[key_slot][0] <= value_x;
          shadow_val[key_slot][1] <= value_y;
          shadow_val[key_slot][2] <= value_z;
          shadow_val[key_slot][3] <= value_w;
        end else begin
          expected_samples.push_back(sample_track(query_time));
        end
      end
      pending <= expected_samples.size();
    end
  end

endmodule

### tb/tb.sv
// testbench top for the keyframe track sampler: stimulus, stalls and verdict
module tb import kts_pkg::*; import kts_tb_pkg::*;;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid, in_stall;
  logic        action;
  logic [7:0]  key_slot;
  logic [31:0] key_time, value_x, value_y, value_z, value_w, query_time;
  logic        out_valid, out_stall;
  logic [31:0] out_x, out_y, out_z, out_w;
  logic [7:0]  segment_index;
  int          fail_count, pending;

  int n_samples = 0;
  int n_writes = 0;
  int n_settings = 0;
  int burst_left = 4;
  longint key_span = 0;

  always #6 clk = ~clk;

  keyframe_track_sampler_core dut (.*);
  keyframe_track_sampler_checker chk (.*);

  // offer one request and hold it until taken, then maybe pause
  task automatic offer(logic act, logic [7:0] slot, logic [31:0] kt, logic [31:0] vx,
                       logic [31:0] vy, logic [31:0] vz, logic [31:0] vw,
                       logic [31:0] q);
    action <= act;
    key_slot <= slot;
    key_time <= kt;
    value_x <= vx;
    value_y <= vy;
    value_z <= vz;
    value_w <= vw;
    query_time <= q;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act == ACT_SAMPLE) n_samples++;
    else n_writes++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 10);
    end
  endtask

  task automatic key_write(int slot, logic [31:0] kt, logic [31:0] vx, logic [31:0] vy,
                           logic [31:0] vz, logic [31:0] vw);
    offer(ACT_KEY_WRITE, slot[7:0], kt, vx, vy, vz, vw, $urandom);
  endtask

  task automatic sample(logic [31:0] q);
    offer(ACT_SAMPLE, 8'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom, q);
  endtask

  // wait until every expected result is back and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || in_stall) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic reg_write(cfg_reg_t idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] dur, logic lp, logic [8:0] tc, logic [8:0] vc);
    drain();
    reg_write(REG_CLIP_DURATION, dur);
    reg_write(REG_LOOP_MODE, {31'd0, lp});
    reg_write(REG_TIME_COUNT, {23'd0, tc});
    reg_write(REG_VALUE_COUNT, {23'd0, vc});
    cfg_valid <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // write slots 0..n-1, sorted with repeats or scrambled
  task automatic load_keys(int n, bit sorted);
    longint t;
    t = ($urandom_range(0, 3) == 0) ? -longint'($urandom_range(0, 3) << 16)
                                    : longint'($urandom_range(0, 4) << 16);
    for (int i = 0; i < n; i++) begin
      if (sorted) key_write(i, t[31:0], rand_value(), rand_value(), rand_value(), rand_value());
      else key_write(i, $urandom, rand_value(), rand_value(), rand_value(), rand_value());
      case ($urandom_range(0, 9))
        0: t = t;
        1, 2: t += $urandom_range(1, 255);
        default: t += $urandom_range(1, 1 << 20);
      endcase
    end
    key_span = (t > 0) ? t : 1;
  endtask

  function automatic logic [31:0] rand_query();
    longint q;
    if ($urandom_range(0, 4) == 0) return $urandom;
    q = longint'($urandom_range(0, 32'(key_span * 3))) - key_span;
    return q[31:0];
  endfunction

  // receiver stalls, with one long hold-off
  initial begin
    int cyc;
    int mode;
    bit held;
    cyc = 0;
    held = 0;
    out_stall <= 1'b0;
    @(negedge rst);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 300)) begin
        @(posedge clk);
        cyc++;
        if (!held && cyc >= 4000) begin
          out_stall <= 1'b1;
          repeat (600) @(posedge clk);
          held = 1;
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          2: out_stall <= ($urandom_range(0, 9) < 8);
          default: out_stall <= (cyc % 7) < 3;
        endcase
      end
    end
  end

  // run limit
  initial begin
    #(12 * 4000000);
    $display("CHECKS FAILED");
    $finish;
  end

  // stimulus and verdict
  initial begin
    longint d;
    int n;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    action <= ACT_KEY_WRITE;
    key_slot <= '0;
    key_time <= '0;
    value_x <= '0;
    value_y <= '0;
    value_z <= '0;
    value_w <= '0;
    query_time <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every slot gets written first, so no count ever reaches unwritten keys
    load_keys(256, 1);

    // empty value table, single value, no times, zero duration
    set_config(32'd0, 1'b0, 9'd0, 9'd0);
    sample(32'h0);
    set_config(32'h7fff_ffff, 1'b0, 9'd256, 9'd1);
    sample(32'h7fff_ffff);
    set_config(32'd0, 1'b1, 9'd0, 9'd5);
    sample(32'h1234_5678);
    set_config(32'd0, 1'b0, 9'd256, 9'd256);
    sample(32'h8000_0000);
    // saturated counts, longest clip, looping
    set_config(32'h7fff_ffff, 1'b1, 9'h1ff, 9'h1ff);
    sample(32'h8000_0000);
    sample(32'h7fff_ffff);
    sample(32'h0);
    sample(32'hffff_ffff);
    // clamped at both ends of the clip
    set_config(32'(key_span + 100), 1'b0, 9'd256, 9'd256);
    sample(32'h8000_0000);
    sample(32'h7fff_ffff);
    sample(32'(key_span / 2));
    // segment past the values, then more values than times
    set_config(32'(key_span), 1'b1, 9'd20, 9'd8);
    sample(rand_query());
    sample(rand_query());
    set_config(32'(key_span), 1'b0, 9'd8, 9'd20);
    sample(rand_query());
    sample(rand_query());
    // extreme components across one segment, then a zero-length segment
    key_write(0, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff);
    key_write(1, 32'h1_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0);
    set_config(32'h1_0000, 1'b0, 9'd2, 9'd2);
    sample(32'h8000);
    sample(32'h1_0000);
    sample(32'h1);
    key_write(1, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0);
    sample(32'h8000);

    // random phases, each with fresh keys and a fresh setting
    while (n_samples + n_writes < 1850) begin
      drain();
      n = ($urandom_range(0, 19) == 0) ? 256 : $urandom_range(2, 16);
      load_keys(n, $urandom_range(0, 9) != 0);
      case ($urandom_range(0, 7))
        0: d = 0;
        1: d = 32'h7fff_ffff;
        2: d = $urandom_range(1, 1000);
        default: d = key_span + $urandom_range(0, 1 << 18);
      endcase
      if (d > 32'h7fff_ffff) d = 32'h7fff_ffff;
      set_config(d[31:0], 1'($urandom_range(0, 1)),
                 ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511)) : 9'(n),
                 ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                             : 9'($urandom_range(n > 2 ? n - 2 : 0, n)));
      repeat ($urandom_range(10, 40)) sample(rand_query());
    end

    drain();
    repeat (100) @(posedge clk);
    $display("run covered %0d samples and %0d key writes over %0d register settings",
             n_samples, n_writes, n_settings);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
